// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the matrix-chain cost block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that must be followed by its consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mcoc_pkg.sv =====
// Package with the shared types and constants of the matrix-chain cost block.
`timescale 1ns / 1ps

package mcoc_pkg;

    localparam int MAX_MATRICES_DEF = 16;
    localparam int DIM_BITS_DEF     = 16;
    localparam int DIM_W            = 16;
    localparam int COST_W           = 52;
    localparam int STATUS_W         = 2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_MANY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SETUP_I,
        S_SETUP_J,
        S_SETUP_MUL,
        S_KLOOP,
        S_DRAIN,
        S_WRITE,
        S_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic dim_wr;
        logic lat_di;
        logic mul_dij;
        logic clr_best;
        logic issue;
        logic wr_cost;
        logic clr_res;
        logic out_load;
    } mcoc_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } mcoc_stat_t;

endpackage

// ===== rtl/mcoc_ctrl.sv =====
// Controller: dimension loading, interval and split sequencing, result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcoc_ctrl import mcoc_pkg::*; #(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    localparam int IDX_W     = $clog2(MAX_MATRICES),
    localparam int DIM_IDX_W = $clog2(MAX_MATRICES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last_dim,
    output logic                 s_ready,
    input  mcoc_stat_t           stat,
    output mcoc_cmd_t            cmd,
    output logic [DIM_IDX_W-1:0] dim_waddr,
    output logic [DIM_IDX_W-1:0] dim_raddr,
    output logic [IDX_W-1:0]     idx_i,
    output logic [IDX_W-1:0]     idx_j,
    output logic [IDX_W-1:0]     idx_k,
    output status_t              res_status
);

    localparam int LEN_W = $clog2(MAX_MATRICES + 1);
    localparam int CNT_W = $clog2(MAX_MATRICES + 3);

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    status_t           st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            len_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            st_reg    <= st_next;
        end
    end

    assign cnt_inc = (cnt_reg < CNT_W'(MAX_MATRICES + 2)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (s_last_dim) begin
                        cnt_next = '0;
                        if (cnt_inc < CNT_W'(2)) begin
                            st_next    = ST_FEW;
                            state_next = S_RESULT;
                        end else if (cnt_inc > CNT_W'(MAX_MATRICES + 1)) begin
                            st_next    = ST_MANY;
                            state_next = S_RESULT;
                        end else begin
                            st_next  = ST_OK;
                            n_next   = LEN_W'(cnt_inc - CNT_W'(1));
                            len_next = LEN_W'(2);
                            i_next   = '0;
                            j_next   = IDX_W'(1);
                            if (cnt_inc == CNT_W'(2)) begin
                                state_next = S_RESULT;
                            end else begin
                                state_next = S_SETUP_I;
                            end
                        end
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            S_SETUP_I: begin
                state_next = S_SETUP_J;
            end
            S_SETUP_J: begin
                state_next = S_SETUP_MUL;
            end
            S_SETUP_MUL: begin
                k_next     = i_reg;
                state_next = S_KLOOP;
            end
            S_KLOOP: begin
                if (k_reg + IDX_W'(1) == j_reg) begin
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (!stat.busy) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (LEN_W'(j_reg) + LEN_W'(1) == n_reg) begin
                    if (len_reg == n_reg) begin
                        state_next = S_RESULT;
                    end else begin
                        len_next   = len_reg + LEN_W'(1);
                        i_next     = '0;
                        j_next     = IDX_W'(len_reg);
                        state_next = S_SETUP_I;
                    end
                end else begin
                    i_next     = i_reg + IDX_W'(1);
                    j_next     = j_reg + IDX_W'(1);
                    state_next = S_SETUP_I;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        dim_raddr = '0;
        unique case (state_reg)
            S_LOAD: begin
                cmd.dim_wr  = s_valid && (cnt_reg < CNT_W'(MAX_MATRICES + 1));
                cmd.clr_res = s_valid && s_last_dim;
            end
            S_SETUP_I: begin
                dim_raddr = DIM_IDX_W'(i_reg);
            end
            S_SETUP_J: begin
                dim_raddr  = DIM_IDX_W'(j_reg) + DIM_IDX_W'(1);
                cmd.lat_di = 1'b1;
            end
            S_SETUP_MUL: begin
                cmd.mul_dij  = 1'b1;
                cmd.clr_best = 1'b1;
            end
            S_KLOOP: begin
                dim_raddr = DIM_IDX_W'(k_reg) + DIM_IDX_W'(1);
                cmd.issue = 1'b1;
            end
            S_DRAIN: begin
                cmd = '0;
            end
            S_WRITE: begin
                cmd.wr_cost = 1'b1;
            end
            S_RESULT: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign s_ready    = (state_reg == S_LOAD);
    assign dim_waddr  = cnt_reg[DIM_IDX_W-1:0];
    assign idx_i      = i_reg;
    assign idx_j      = j_reg;
    assign idx_k      = k_reg;
    assign res_status = st_reg;

    `ASSERT_IMPLIES(a_split_in_interval, aclk, aresetn, state_reg == S_KLOOP,
        (k_reg >= i_reg) && (k_reg < j_reg), "split index left its interval")

endmodule

// ===== rtl/mcoc_dpath.sv =====
// Datapath: dimension store, cost table, split-cost pipeline and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcoc_dpath import mcoc_pkg::*; #(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int DIM_BITS     = DIM_BITS_DEF,
    localparam int IDX_W     = $clog2(MAX_MATRICES),
    localparam int DIM_IDX_W = $clog2(MAX_MATRICES + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mcoc_cmd_t            cmd,
    output mcoc_stat_t           stat,
    input  logic [DIM_W-1:0]     dim_in,
    input  logic [DIM_IDX_W-1:0] dim_waddr,
    input  logic [DIM_IDX_W-1:0] dim_raddr,
    input  logic [IDX_W-1:0]     idx_i,
    input  logic [IDX_W-1:0]     idx_j,
    input  logic [IDX_W-1:0]     idx_k,
    input  status_t              res_status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COST_W-1:0]    m_min_cost,
    output logic [STATUS_W-1:0]  m_status,
    output logic                 m_saturated
);

    localparam int DEPTH_DIMS = MAX_MATRICES + 1;
    localparam int COST_AW    = 2 * IDX_W;
    localparam int DEPTH_COST = 1 << COST_AW;
    localparam int DIJ_W      = 2 * DIM_BITS;
    localparam int PROD_W     = 3 * DIM_BITS;
    localparam int CSUM_W     = COST_W + 1;
    localparam int TSUM_W     = COST_W + 2;

    logic [DIM_BITS-1:0] dim_mem [0:DEPTH_DIMS-1];
    logic [COST_W-1:0]   cost_mem [0:DEPTH_COST-1];

    logic [DIM_BITS-1:0] dim_rd_reg;
    logic [DIM_BITS-1:0] di_reg;
    logic [DIJ_W-1:0]    dij_reg;
    logic [COST_W-1:0]   c1_reg, c2_reg;
    logic                z1_reg, z2_reg;
    logic                v1_reg, v2_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [CSUM_W-1:0]   csum_reg;
    logic [COST_W-1:0]   best_reg;
    logic [COST_W-1:0]   res_reg;
    logic                sat_reg;
    logic                m_valid_reg;
    logic [COST_W-1:0]   m_cost_reg;
    status_t             m_status_reg;
    logic                m_sat_reg;

    logic [IDX_W-1:0]    k_p1;
    logic [TSUM_W-1:0]   t_sum;
    logic [COST_W-1:0]   t_clamp;
    logic                out_free;

    assign k_p1 = idx_k + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.dim_wr) begin
            dim_mem[dim_waddr] <= dim_in[DIM_BITS-1:0];
        end
        dim_rd_reg <= dim_mem[dim_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_cost) begin
            cost_mem[{idx_i, idx_j}] <= best_reg;
        end
        c1_reg <= cost_mem[{idx_i, idx_k}];
        c2_reg <= cost_mem[{k_p1, idx_j}];
    end

    always_ff @(posedge aclk) begin
        z1_reg <= (idx_k == idx_i);
        z2_reg <= (k_p1 == idx_j);
        if (cmd.lat_di) begin
            di_reg <= dim_rd_reg;
        end
        if (cmd.mul_dij) begin
            dij_reg <= DIJ_W'(di_reg) * DIJ_W'(dim_rd_reg);
        end
        prod_reg <= PROD_W'(dij_reg) * PROD_W'(dim_rd_reg);
        csum_reg <= CSUM_W'(z1_reg ? '0 : c1_reg) + CSUM_W'(z2_reg ? '0 : c2_reg);
    end

    assign t_sum   = TSUM_W'(csum_reg) + TSUM_W'(prod_reg);
    assign t_clamp = (t_sum >= TSUM_W'(COST_MAX)) ? COST_MAX : t_sum[COST_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.clr_best) begin
            best_reg <= COST_MAX;
        end else if (v2_reg && (t_clamp < best_reg)) begin
            best_reg <= t_clamp;
        end
        if (cmd.clr_res) begin
            res_reg <= '0;
        end else if (cmd.wr_cost) begin
            res_reg <= best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (cmd.clr_res) begin
                sat_reg <= 1'b0;
            end else if (cmd.wr_cost && (best_reg == COST_MAX)) begin
                sat_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_cost_reg   <= res_reg;
            m_status_reg <= res_status;
            m_sat_reg    <= sat_reg;
        end
    end

    assign out_free      = !m_valid_reg || m_ready;
    assign stat.busy     = v1_reg || v2_reg;
    assign stat.out_free = out_free;

    assign m_valid     = m_valid_reg;
    assign m_min_cost  = m_cost_reg;
    assign m_status    = m_status_reg;
    assign m_saturated = m_sat_reg;

    `ASSERT_ALWAYS(a_write_after_drain, aclk, aresetn, !(cmd.wr_cost && (v1_reg || v2_reg)),
        "cost written while split pipeline still busy")
    `ASSERT_IMPLIES(a_load_into_free, aclk, aresetn, cmd.out_load, out_free,
        "result loaded over an item not yet taken")
    `ASSERT_IMPLIES(a_sat_only_ok, aclk, aresetn, m_valid_reg && m_sat_reg,
        m_status_reg == ST_OK, "saturation reported on an error result")

endmodule

// ===== rtl/matrix_chain_order_cost.sv =====
// Top level: minimum matrix-chain multiplication cost over a streamed dimension list.
// Dimensions are taken one per cycle while s_ready is high; a non-final item yields no result.
// After the final item of n matrices the table fill runs, per interval of length L,
// the setup states, L-1 splits (one per cycle), a drain until the pipeline is idle and a write.
// The result is then loaded once the output register is free; error chains skip the fill.
// Reset (aresetn low, synchronous) clears control state; the stores are not cleared.
`timescale 1ns / 1ps

module matrix_chain_order_cost import mcoc_pkg::*; #(
    parameter int MAX_MATRICES = MAX_MATRICES_DEF,
    parameter int DIM_BITS     = DIM_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DIM_W-1:0]    s_dim,
    input  logic                s_last_dim,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COST_W-1:0]   m_min_cost,
    output logic [STATUS_W-1:0] m_status,
    output logic                m_saturated
);

    localparam int IDX_W     = $clog2(MAX_MATRICES);
    localparam int DIM_IDX_W = $clog2(MAX_MATRICES + 1);

    mcoc_cmd_t            cmd;
    mcoc_stat_t           stat;
    logic [DIM_IDX_W-1:0] dim_waddr;
    logic [DIM_IDX_W-1:0] dim_raddr;
    logic [IDX_W-1:0]     idx_i;
    logic [IDX_W-1:0]     idx_j;
    logic [IDX_W-1:0]     idx_k;
    status_t              res_status;

    mcoc_ctrl #(
        .MAX_MATRICES (MAX_MATRICES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_last_dim (s_last_dim),
        .s_ready    (s_ready),
        .stat       (stat),
        .cmd        (cmd),
        .dim_waddr  (dim_waddr),
        .dim_raddr  (dim_raddr),
        .idx_i      (idx_i),
        .idx_j      (idx_j),
        .idx_k      (idx_k),
        .res_status (res_status)
    );

    mcoc_dpath #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_BITS     (DIM_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .dim_in      (s_dim),
        .dim_waddr   (dim_waddr),
        .dim_raddr   (dim_raddr),
        .idx_i       (idx_i),
        .idx_j       (idx_j),
        .idx_k       (idx_k),
        .res_status  (res_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_cost  (m_min_cost),
        .m_status    (m_status),
        .m_saturated (m_saturated)
    );

endmodule
